// ===== hdl/barometric_pressure_compensation_top_macros.svh =====
// Assertion macros for the barometric pressure compensation block.
// Used by the port checker; no other dependencies.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpc_pkg.sv =====
// Shared codes and constants for the barometric pressure compensation block.
// No dependencies.
package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic OpTemp = 1'b0;
  localparam logic OpPres = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgOversampling = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCalA         = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCalB         = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCalC         = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCalD         = 3'd4;

  localparam logic signed [31:0] B5Offset   = 32'sd4000;
  localparam logic signed [31:0] TempRound  = 32'sd8;
  localparam logic signed [23:0] PresK1     = 24'sd3038;
  localparam logic signed [23:0] PresK2     = -24'sd7357;
  localparam logic signed [47:0] PresK3     = 48'sd3791;
  localparam logic signed [47:0] B4Bias     = 48'sd32768;
  localparam logic        [15:0] B7Scale    = 16'd50000;

endpackage

// ===== hdl/barometric_pressure_compensation_top.sv =====
// Barometric pressure compensation: shared multiplier and radix-2 divider
// under one sequencer. Depends on bpc_pkg.
//
// channel  dir  handshake                        payload
// s_axis   in   s_axis_tvalid / s_axis_tready    tdata raw_reading, tuser operation
// m_axis   out  m_axis_tvalid / m_axis_tready    tdata value, tuser kind, div_error
// cfg      in   cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// A new item is accepted only in idle, once the previous item has been emitted.
// Item time is set by the 32-step divider plus one pass per multiply on the shared unit.
// A zero divisor skips the divider and emits a zero value with div_error set.
// Reset loads oversampling 1, calibration 0 and the stored B6 term 0.
// A stalled output holds the sequencer before its last step; cfg is always ready.
module barometric_pressure_compensation_top
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // [23:0] raw_reading
  input  logic [0:0]          s_axis_tuser,   // [0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [31:0] value
  output logic [1:0]          m_axis_tuser,   // [0] kind, [1] div_error
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [47:0]         cfg_data_i
);

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] STMul = 5'd1;
  localparam logic [4:0] STDen = 5'd2;
  localparam logic [4:0] STFin = 5'd3;
  localparam logic [4:0] SPSq0 = 5'd4;
  localparam logic [4:0] SPSq1 = 5'd5;
  localparam logic [4:0] SPSq2 = 5'd6;
  localparam logic [4:0] SPX1  = 5'd7;
  localparam logic [4:0] SPX2  = 5'd8;
  localparam logic [4:0] SPB3  = 5'd9;
  localparam logic [4:0] SPX3  = 5'd10;
  localparam logic [4:0] SPB4  = 5'd11;
  localparam logic [4:0] SPB7  = 5'd12;
  localparam logic [4:0] SPChk = 5'd13;
  localparam logic [4:0] SPT1  = 5'd14;
  localparam logic [4:0] SPT2  = 5'd15;
  localparam logic [4:0] SPX7  = 5'd16;
  localparam logic [4:0] SPFin = 5'd17;
  localparam logic [4:0] SDiv  = 5'd18;
  localparam logic [4:0] SEmit = 5'd19;

  // control state
  logic [4:0]         state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] b6_q, b6_d;
  logic [1:0]         oss_q, oss_d;
  logic [47:0]        cal_a_q, cal_a_d;
  logic [47:0]        cal_b_q, cal_b_d;
  logic [31:0]        cal_c_q, cal_c_d;
  logic [31:0]        cal_d_q, cal_d_d;
  logic [4:0]         div_cnt_q, div_cnt_d;

  // datapath
  logic               op_q, op_d;
  logic [23:0]        raw_q, raw_d;
  logic signed [68:0] prod_q, prod_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [43:0] sq_q, sq_d;
  logic signed [47:0] x1_q, x1_d;
  logic [31:0]        b3_q, b3_d;
  logic [16:0]        b4_q, b4_d;
  logic [31:0]        b7_q, b7_d;
  logic signed [31:0] p_q, p_d;
  logic               qneg_q, qneg_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        quo_q, quo_d;
  logic [31:0]        dvs_q, dvs_d;
  logic [31:0]        res_value_q, res_value_d;
  logic               res_err_q, res_err_d;
  logic               out_kind_q, out_kind_d;
  logic [31:0]        out_value_q, out_value_d;
  logic               out_err_q, out_err_d;

  logic signed [44:0] mul_a;
  logic signed [23:0] mul_b;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  logic signed [16:0] ut_diff;
  logic signed [17:0] tx1;
  logic signed [18:0] den;
  logic signed [26:0] num;
  logic        [26:0] num_mag;
  logic        [18:0] den_mag;
  logic signed [27:0] q_s;
  logic signed [27:0] tx2;
  logic signed [31:0] b5;

  logic signed [63:0] sq_full;
  logic signed [47:0] px2_11, px2_16, x3_b3, x3_b4, corr, pf;
  logic signed [50:0] b3_pre, b3_scaled;
  logic        [31:0] b4_arg;
  logic        [3:0]  up_sh;
  logic        [31:0] up, up_diff;
  logic        [31:0] b7_now, pu;
  logic signed [23:0] t_new, t_old;

  logic [32:0] div_sh;
  logic [33:0] div_diff;

  logic in_acc, out_acc, cfg_acc;

  assign s_axis_tready = (state_q == SIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = out_valid_q & m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {out_err_q, out_kind_q};

  assign ac1 = cal_a_q[47:32];
  assign ac2 = cal_a_q[31:16];
  assign ac3 = cal_a_q[15:0];
  assign ac4 = cal_b_q[47:32];
  assign ac5 = cal_b_q[31:16];
  assign ac6 = cal_b_q[15:0];
  assign b1  = cal_c_q[31:16];
  assign b2  = cal_c_q[15:0];
  assign mc  = cal_d_q[31:16];
  assign md  = cal_d_q[15:0];

  // temperature terms
  assign ut_diff = signed'({1'b0, raw_q[15:0]}) - signed'({1'b0, ac6});
  assign tx1     = 18'(prod_q >>> 15);
  assign den     = 19'(tx1) + 19'(md);
  assign num     = 27'(mc) <<< 11;
  assign num_mag = num[26] ? 27'(-num) : 27'(num);
  assign den_mag = den[18] ? 19'(-den) : 19'(den);
  assign q_s     = signed'({1'b0, quo_q[26:0]});
  assign tx2     = qneg_q ? -q_s : q_s;
  assign b5      = 32'(x1_q) + 32'(tx2);

  // pressure terms
  assign sq_full   = acc_q + (64'(prod_q) <<< 14);
  assign px2_11    = 48'(prod_q >>> 11);
  assign px2_16    = 48'(prod_q >>> 16);
  assign x3_b3     = x1_q + px2_11;
  assign b3_pre    = (51'(ac1) <<< 2) + 51'(x3_b3);
  assign b3_scaled = ((b3_pre <<< oss_q) + 51'sd2) >>> 2;
  assign x3_b4     = (x1_q + 48'(prod_q >>> 16) + 48'sd2) >>> 2;
  assign b4_arg    = 32'(x3_b4 + B4Bias);
  assign up_sh     = 4'd8 - {2'b00, oss_q};
  assign up        = {8'd0, raw_q >> up_sh};
  assign up_diff   = up - b3_q;
  assign b7_now    = prod_q[31:0];
  assign pu        = b7_q[31] ? {quo_q[30:0], 1'b0} : quo_q;
  assign t_new     = pu[31:8];
  assign t_old     = p_q[31:8];
  assign corr      = (x1_q + px2_16 + PresK3) >>> 4;
  assign pf        = 48'(p_q) + corr;

  // divider step
  assign div_sh   = {rem_q, quo_q[31]};
  assign div_diff = {1'b0, div_sh} - {2'b00, dvs_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      STMul: begin
        mul_a = 45'(ut_diff);
        mul_b = 24'(signed'({1'b0, ac5}));
      end
      SPSq0: begin
        mul_a = 45'(b6_q);
        mul_b = signed'({10'd0, b6_q[13:0]});
      end
      SPSq1: begin
        mul_a = 45'(b6_q);
        mul_b = 24'(b6_q >>> 14);
      end
      SPX1: begin
        mul_a = 45'(sq_q);
        mul_b = 24'(b2);
      end
      SPX2: begin
        mul_a = 45'(b6_q);
        mul_b = 24'(ac2);
      end
      SPB3: begin
        mul_a = 45'(b6_q);
        mul_b = 24'(ac3);
      end
      SPX3: begin
        mul_a = 45'(sq_q);
        mul_b = 24'(b1);
      end
      SPB4: begin
        mul_a = signed'({13'd0, b4_arg});
        mul_b = signed'({8'd0, ac4});
      end
      SPB7: begin
        mul_a = signed'({13'd0, up_diff});
        mul_b = signed'({8'd0, B7Scale >> oss_q});
      end
      SPT1: begin
        mul_a = 45'(t_new);
        mul_b = PresK1;
      end
      SPT2: begin
        mul_a = 45'(prod_q);
        mul_b = t_old;
      end
      SPX7: begin
        mul_a = 45'(p_q);
        mul_b = PresK2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = 69'(mul_a) * 69'(mul_b);

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    b6_d        = b6_q;
    oss_d       = oss_q;
    cal_a_d     = cal_a_q;
    cal_b_d     = cal_b_q;
    cal_c_d     = cal_c_q;
    cal_d_d     = cal_d_q;
    div_cnt_d   = div_cnt_q;
    op_d        = op_q;
    raw_d       = raw_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    x1_d        = x1_q;
    b3_d        = b3_q;
    b4_d        = b4_q;
    b7_d        = b7_q;
    p_d         = p_q;
    qneg_d      = qneg_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    res_value_d = res_value_q;
    res_err_d   = res_err_q;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;

    if (cfg_acc) begin
      case (cfg_index_i)
        CfgOversampling: oss_d   = cfg_data_i[1:0];
        CfgCalA:         cal_a_d = cfg_data_i;
        CfgCalB:         cal_b_d = cfg_data_i;
        CfgCalC:         cal_c_d = cfg_data_i[31:0];
        CfgCalD:         cal_d_d = cfg_data_i[31:0];
        default: ;
      endcase
    end

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          op_d    = s_axis_tuser[0];
          raw_d   = s_axis_tdata;
          state_d = (s_axis_tuser[0] == OpPres) ? SPSq0 : STMul;
        end
      end
      STMul: state_d = STDen;
      STDen: begin
        x1_d = 48'(tx1);
        if (den == 19'sd0) begin
          res_value_d = '0;
          res_err_d   = 1'b1;
          state_d     = SEmit;
        end else begin
          qneg_d    = num[26] ^ den[18];
          rem_d     = '0;
          quo_d     = 32'(num_mag);
          dvs_d     = 32'(den_mag);
          div_cnt_d = '0;
          state_d   = SDiv;
        end
      end
      STFin: begin
        b6_d        = b5 - B5Offset;
        res_value_d = 32'((b5 + TempRound) >>> 4);
        res_err_d   = 1'b0;
        state_d     = SEmit;
      end
      SPSq0: state_d = SPSq1;
      SPSq1: begin
        acc_d   = 64'(prod_q);
        state_d = SPSq2;
      end
      SPSq2: begin
        sq_d    = 44'(sq_full >>> 12);
        state_d = SPX1;
      end
      SPX1: state_d = SPX2;
      SPX2: begin
        x1_d    = px2_11;
        state_d = SPB3;
      end
      SPB3: begin
        b3_d    = b3_scaled[31:0];
        state_d = SPX3;
      end
      SPX3: begin
        x1_d    = 48'(prod_q >>> 13);
        state_d = SPB4;
      end
      SPB4: state_d = SPB7;
      SPB7: begin
        b4_d    = prod_q[31:15];
        state_d = SPChk;
      end
      SPChk: begin
        b7_d = b7_now;
        if (b4_q == '0) begin
          res_value_d = '0;
          res_err_d   = 1'b1;
          state_d     = SEmit;
        end else begin
          rem_d     = '0;
          quo_d     = b7_now[31] ? b7_now : {b7_now[30:0], 1'b0};
          dvs_d     = {15'd0, b4_q};
          div_cnt_d = '0;
          state_d   = SDiv;
        end
      end
      SPT1: begin
        p_d     = signed'(pu);
        state_d = SPT2;
      end
      SPT2: state_d = SPX7;
      SPX7: begin
        x1_d    = px2_16;
        state_d = SPFin;
      end
      SPFin: begin
        res_value_d = pf[31:0];
        res_err_d   = 1'b0;
        state_d     = SEmit;
      end
      SDiv: begin
        if (!div_diff[33]) begin
          rem_d = div_diff[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = div_sh[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31) begin
          state_d = (op_q == OpTemp) ? STFin : SPT1;
        end
      end
      SEmit: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_kind_d  = op_q;
          out_value_d = res_value_q;
          out_err_d   = res_err_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      b6_q        <= '0;
      oss_q       <= 2'd1;
      cal_a_q     <= '0;
      cal_b_q     <= '0;
      cal_c_q     <= '0;
      cal_d_q     <= '0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      b6_q        <= b6_d;
      oss_q       <= oss_d;
      cal_a_q     <= cal_a_d;
      cal_b_q     <= cal_b_d;
      cal_c_q     <= cal_c_d;
      cal_d_q     <= cal_d_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    raw_q       <= raw_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    sq_q        <= sq_d;
    x1_q        <= x1_d;
    b3_q        <= b3_d;
    b4_q        <= b4_d;
    b7_q        <= b7_d;
    p_q         <= p_d;
    qneg_q      <= qneg_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dvs_q       <= dvs_d;
    res_value_q <= res_value_d;
    res_err_q   <= res_err_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

endmodule

// ===== hdl/bpc_checker.sv =====
// Port checker for the barometric pressure compensation block, bound to the top.
// Depends on bpc_pkg and barometric_pressure_compensation_top_macros.svh.
`include "barometric_pressure_compensation_top_macros.svh"

module bpc_checker
  import bpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [31:0]         m_axis_tdata,   // [31:0] value
  input logic [1:0]          m_axis_tuser    // [0] kind, [1] div_error
);

  `BPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")

  `BPC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted item")

  `BPC_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 32'd0, "divide error with nonzero value")

  `BPC_ASSERT_NOW(a_temp_range, m_axis_tvalid && (m_axis_tuser[0] == OpTemp), (m_axis_tdata[31:23] == 9'h000) || (m_axis_tdata[31:23] == 9'h1FF), "temperature value out of range")

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
// Self-checking bench for barometric_pressure_compensation_top: directed and random
// temperature and pressure items are scored against a predictor kept in this file.
// Depends on bpc_pkg and the top-level block only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int StallLen   = 300;
  localparam int TailCycles = 64;

  localparam logic [47:0] SheetCalA = {16'sd408, -16'sd72, -16'sd14383};
  localparam logic [47:0] SheetCalB = {16'd32741, 16'd32757, 16'd23153};
  localparam logic [31:0] SheetCalC = {16'sd6190, 16'sd4};
  localparam logic [31:0] SheetCalD = {-16'sd8711, 16'sd2868};

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        div_error;
  } compensated_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;   // [23:0] raw_reading
  logic [0:0]          s_axis_tuser  = '0;   // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;         // [31:0] value
  logic [1:0]          m_axis_tuser;         // [0] kind, [1] div_error
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [47:0]         cfg_data_i    = '0;

  logic [1:0]          oss_q;
  logic [47:0]         cal_a, cal_b;
  logic [31:0]         cal_c, cal_d;
  logic signed [31:0]  b6_term;

  compensated_t        due_readings[$];
  int                  bad_fields    = 0;
  int                  quiet_cycles  = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  logic                stall_start   = 1'b0;
  int                  stall_left    = 0;

  barometric_pressure_compensation_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic compensated_t compensate(input logic op, input logic [23:0] raw);
    compensated_t r;
    longint ut, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    longint x1, x2, x3, den, b5, b6, sq, b3, p, t, wide;
    logic [31:0] ac4, up, prod, b4, b7, pu;
    r.kind      = op;
    r.value     = '0;
    r.div_error = 1'b0;
    ac1 = $signed(cal_a[47:32]);
    ac2 = $signed(cal_a[31:16]);
    ac3 = $signed(cal_a[15:0]);
    ac4 = {16'b0, cal_b[47:32]};
    ac5 = cal_b[31:16];
    ac6 = cal_b[15:0];
    b1  = $signed(cal_c[31:16]);
    b2  = $signed(cal_c[15:0]);
    mc  = $signed(cal_d[31:16]);
    md  = $signed(cal_d[15:0]);
    if (op == OpTemp) begin
      ut  = raw[15:0];
      x1  = ((ut - ac6) * ac5) >>> 15;
      den = x1 + md;
      if (den == 0) begin
        r.div_error = 1'b1;
      end else begin
        x2      = (mc * 2048) / den;
        b5      = x1 + x2;
        wide    = b5 - 4000;
        b6_term = wide[31:0];
        wide    = (b5 + 8) >>> 4;
        r.value = wide[31:0];
      end
    end else begin
      b6   = b6_term;
      up   = {8'b0, raw} >> (4'd8 - {2'b0, oss_q});
      sq   = (b6 * b6) >>> 12;
      x1   = (sq * b2) >>> 11;
      x2   = (ac2 * b6) >>> 11;
      b3   = ((ac1 * 4 + x1 + x2) * (longint'(1) << oss_q) + 2) >>> 2;
      x1   = (ac3 * b6) >>> 13;
      x2   = (b1 * sq) >>> 16;
      x3   = (x1 + x2 + 2) >>> 2;
      wide = x3 + 32768;
      prod = ac4 * wide[31:0];
      b4   = prod >> 15;
      b7   = (up - b3[31:0]) * (32'd50000 >> oss_q);
      if (b4 == 32'd0) begin
        r.div_error = 1'b1;
      end else begin
        if (b7 < 32'h8000_0000) pu = (b7 << 1) / b4;
        else pu = (b7 / b4) * 32'd2;
        p  = $signed(pu);
        t  = p >>> 8;
        x1 = (t * t * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p  = p + ((x1 + x2 + 3791) >>> 4);
        r.value = p[31:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    compensated_t want, got;
    if (!rst_ni) begin
      oss_q   = 2'd1;
      cal_a   = '0;
      cal_b   = '0;
      cal_c   = '0;
      cal_d   = '0;
      b6_term = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgOversampling: oss_q = cfg_data_i[1:0];
          CfgCalA:         cal_a = cfg_data_i;
          CfgCalB:         cal_b = cfg_data_i;
          CfgCalC:         cal_c = cfg_data_i[31:0];
          CfgCalD:         cal_d = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_readings.push_back(compensate(s_axis_tuser[0], s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = m_axis_tuser[0];
        got.value     = m_axis_tdata;
        got.div_error = m_axis_tuser[1];
        if (due_readings.size() == 0) begin
          $display("%0t ns: unexpected item kind %0d value %0d div_error %0d", $time,
                   got.kind, $signed(got.value), got.div_error);
          bad_fields++;
        end else begin
          want = due_readings.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t ns: kind expected %0d actual %0d", $time, want.kind, got.kind);
            bad_fields++;
          end
          if (got.value !== want.value) begin
            $display("%0t ns: value expected %0d actual %0d", $time,
                     $signed(want.value), $signed(got.value));
            bad_fields++;
          end
          if (got.div_error !== want.div_error) begin
            $display("%0t ns: div_error expected %0d actual %0d", $time,
                     want.div_error, got.div_error);
            bad_fields++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_start) stall_left = StallLen;
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ns: no item moved for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_reading(input logic op, input logic [23:0] raw);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and hold until every predicted item has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [1:0] oss, input logic [47:0] a, b,
                              input logic [31:0] c, d);
    put_reg(CfgOversampling, {46'b0, oss});
    put_reg(CfgCalA, a);
    put_reg(CfgCalB, b);
    put_reg(CfgCalC, {16'b0, c});
    put_reg(CfgCalD, {16'b0, d});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] near(input int base);
    return 16'(base + int'($urandom_range(1024, 0)) - 512);
  endfunction

  task automatic load_random_setting();
    logic [1:0] oss;
    oss = 2'($urandom);
    if ($urandom_range(1, 0) == 0) begin
      program_regs(oss, {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                   32'($urandom), 32'($urandom));
    end else begin
      program_regs(oss, {near(408), near(-72), near(-14383)},
                   {near(32741), near(32757), near(23153)},
                   {near(6190), near(4)}, {near(-8711), near(2868)});
    end
  endtask

  task automatic send_plausible_pair();
    logic [23:0] raw;
    raw = 24'($urandom_range(45000, 20000)) << (4'd8 - {2'b0, oss_q});
    raw = raw | (24'($urandom_range(255, 0)) >> oss_q);
    send_reading(OpTemp, {8'($urandom), 16'($urandom_range(35000, 20000))});
    send_reading(OpPres, raw);
  endtask

  task automatic test_reset_state();
    send_reading(OpPres, 24'hFF_FFFF);
    send_reading(OpTemp, 24'h00_0000);
    send_reading(OpTemp, 24'hFF_FFFF);
    drain();
  endtask

  task automatic test_datasheet_point();
    program_regs(2'd0, SheetCalA, SheetCalB, SheetCalC, SheetCalD);
    send_reading(OpTemp, 24'd27898);
    send_reading(OpPres, 24'd23843 << 8);
    send_reading(OpTemp, 24'h00_0000);
    send_reading(OpTemp, 24'hFF_6CFA);
    send_reading(OpTemp, 24'h00_FFFF);
    send_reading(OpPres, 24'h00_0000);
    send_reading(OpPres, 24'hFF_FFFF);
    drain();
    program_regs(2'd3, SheetCalA, SheetCalB, SheetCalC, SheetCalD);
    send_reading(OpPres, 24'd23843 << 5);
    send_reading(OpPres, 24'hFF_FFFF);
    drain();
  endtask

  task automatic test_zero_divisors();
    // x1 equals ut here, so md = -100 cancels it at ut = 100
    program_regs(2'd1, SheetCalA, {16'd32741, 16'h8000, 16'd0}, SheetCalC,
                 {-16'sd8711, -16'sd100});
    send_reading(OpTemp, 24'h00_0064);
    send_reading(OpTemp, 24'hAB_0064);
    send_reading(OpPres, 24'd30000 << 7);
    send_reading(OpTemp, 24'h00_00C8);
    drain();
    program_regs(2'd2, SheetCalA, {16'd0, 16'd32757, 16'd23153}, SheetCalC, SheetCalD);
    send_reading(OpPres, 24'd30000 << 6);
    drain();
  endtask

  task automatic test_extreme_calibration();
    program_regs(2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_reading(OpTemp, 24'h00_FFFF);
    send_reading(OpPres, 24'hFF_FFFF);
    send_reading(OpTemp, 24'h00_0000);
    send_reading(OpPres, 24'h00_0000);
    drain();
    program_regs(2'd0, 48'h8000_8000_8000, 48'hFFFF_7FFF_0000, 32'h8000_7FFF, 32'h8000_0001);
    send_reading(OpTemp, 24'h00_FFFF);
    send_reading(OpPres, 24'hFF_FFFF);
    send_reading(OpTemp, 24'h00_0000);
    send_reading(OpPres, 24'h00_0000);
    drain();
  endtask

  task automatic test_random_traffic();
    int send_pct [3] = '{18, 86, 0};
    int recv_pct [3] = '{86, 18, 0};
    int sent;
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_pct[m];
      recv_idle_pct <= recv_pct[m];
      for (int k = 0; k < 3; k++) begin
        load_random_setting();
        sent = 0;
        while (sent < 55) begin
          if ($urandom_range(9, 0) < 7) begin
            send_plausible_pair();
            sent += 2;
          end else begin
            send_reading(1'($urandom), 24'($urandom));
            sent++;
          end
        end
        drain();
      end
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    load_random_setting();
    stall_start <= 1'b1;
    @(posedge clk_i);
    stall_start <= 1'b0;
    for (int i = 0; i < 6; i++) send_plausible_pair();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_datasheet_point();
    test_zero_divisors();
    test_extreme_calibration();
    test_random_traffic();
    test_output_stall();
    repeat (TailCycles) @(posedge clk_i);
    if (bad_fields == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
